FILE: src/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// shared types and constants for the c comment stripper
// ----------------------------------------------------------------------------
package ccs_pkg;

  // character codes
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // one result item
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } result_t;

  // results produced by one accepted item, handed to the queue
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: src/ccs_decode.sv
// ----------------------------------------------------------------------------
// ccs_decode
// comment/string state flags and per-byte decode into zero to two results
// ----------------------------------------------------------------------------
module ccs_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     in_char,
  output ccs_pkg::push_t push
);

  logic in_block_comment, in_block_comment_next;
  logic in_line_comment,  in_line_comment_next;
  logic in_quoted_string, in_quoted_string_next;
  logic slash_pending,    slash_pending_next;
  logic star_seen,        star_seen_next;
  logic [1:0] num;
  logic [7:0] c0, c1;

  always_comb begin
    in_block_comment_next = in_block_comment;
    in_line_comment_next  = in_line_comment;
    in_quoted_string_next = in_quoted_string;
    slash_pending_next    = slash_pending;
    star_seen_next        = star_seen;
    num = 2'd0;
    c0  = in_char;
    c1  = in_char;

    if (in_char == ccs_pkg::CH_NEWLINE) begin
      if (in_line_comment) begin
        in_line_comment_next = 1'b0;
        num = 2'd1;
      end else if (!in_block_comment) begin
        if (slash_pending) begin
          num = 2'd2;
          c0  = ccs_pkg::CH_SLASH;
        end else begin
          num = 2'd1;
        end
      end
      in_quoted_string_next = 1'b0;
      slash_pending_next    = 1'b0;
      star_seen_next        = 1'b0;
    end else if (in_line_comment) begin
      // dropped until end of line
    end else if (in_char == ccs_pkg::CH_SLASH && !in_quoted_string) begin
      if (in_block_comment) begin
        if (star_seen) begin
          in_block_comment_next = 1'b0;
        end
        star_seen_next     = 1'b0;
        slash_pending_next = 1'b0;
      end else if (slash_pending) begin
        in_line_comment_next = 1'b1;
        slash_pending_next   = 1'b0;
      end else begin
        slash_pending_next = 1'b1;
      end
    end else if (in_char == ccs_pkg::CH_STAR && !in_quoted_string) begin
      if (in_block_comment) begin
        star_seen_next = 1'b1;
      end else if (slash_pending) begin
        in_block_comment_next = 1'b1;
        slash_pending_next    = 1'b0;
        star_seen_next        = 1'b0;
      end else begin
        num = 2'd1;
      end
    end else begin
      if (in_block_comment) begin
        star_seen_next = 1'b0;
      end else begin
        if (in_char == ccs_pkg::CH_QUOTE) begin
          in_quoted_string_next = !in_quoted_string;
        end
        if (slash_pending) begin
          num = 2'd2;
          c0  = ccs_pkg::CH_SLASH;
        end else begin
          num = 2'd1;
        end
        slash_pending_next = 1'b0;
      end
    end

    push.num     = accept ? num : 2'd0;
    push.r0.ch   = c0;
    push.r0.last = (num == 2'd1);
    push.r1.ch   = c1;
    push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_block_comment <= 1'b0;
      in_line_comment  <= 1'b0;
      in_quoted_string <= 1'b0;
      slash_pending    <= 1'b0;
      star_seen        <= 1'b0;
    end else if (accept) begin
      in_block_comment <= in_block_comment_next;
      in_line_comment  <= in_line_comment_next;
      in_quoted_string <= in_quoted_string_next;
      slash_pending    <= slash_pending_next;
      star_seen        <= star_seen_next;
    end
  end

  // the two comment kinds exclude each other
  assert property (@(posedge clk) disable iff (rst)
    !(in_block_comment && in_line_comment))
    else $error("block and line comment open together");

  // a held slash only exists in plain text
  assert property (@(posedge clk) disable iff (rst)
    slash_pending |-> (!in_block_comment && !in_line_comment))
    else $error("slash held inside a comment");

  // star tracking only matters inside a block comment
  assert property (@(posedge clk) disable iff (rst)
    star_seen |-> in_block_comment)
    else $error("star flag set outside block comment");

endmodule

FILE: src/ccs_out_queue.sv
// ----------------------------------------------------------------------------
// ccs_out_queue
// small result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module ccs_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  ccs_pkg::push_t       push,
  input  logic                 pop,
  output logic                 almost_full,
  output logic                 not_empty,
  output ccs_pkg::result_t     head_item
);

  ccs_pkg::result_t mem [ccs_pkg::QUEUE_DEPTH];

  logic [ccs_pkg::PTR_W-1:0] head, head_next;
  logic [ccs_pkg::PTR_W-1:0] tail, tail_next;
  logic [ccs_pkg::CNT_W-1:0] count, count_next;
  logic                      do_pop;

  assign do_pop      = pop && (count != '0);
  assign not_empty   = (count != '0);
  assign almost_full = (count > ccs_pkg::CNT_W'(ccs_pkg::QUEUE_DEPTH - 2));
  assign head_item   = mem[head];

  always_comb begin
    head_next  = do_pop ? head + 1'b1 : head;
    tail_next  = tail + ccs_pkg::PTR_W'(push.num);
    count_next = count + ccs_pkg::CNT_W'(push.num) - ccs_pkg::CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[tail] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem[tail + 1'b1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // never more items than slots
  assert property (@(posedge clk) disable iff (rst)
    count <= ccs_pkg::CNT_W'(ccs_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // a pop with no push takes exactly one item away
  assert property (@(posedge clk) disable iff (rst)
    (do_pop && push.num == 2'd0) |=> (count == $past(count) - 1'b1))
    else $error("result queue count slip on pop");

endmodule

FILE: src/c_comment_stripper.sv
// ----------------------------------------------------------------------------
// c_comment_stripper
// removes c block and line comments from a byte stream
// ----------------------------------------------------------------------------
// usage
//   input channel: in_char with in_valid / in_stall, one source byte per item
//   output channel: out_char and last_of_run with out_valid / out_stall
//   each input item gives zero, one or two result items; last_of_run marks
//   the final result caused by an input item
//   an accepted item's results are written into the registered result queue
//   and reach the output from its head
//   throughput: one input item per cycle while the queue has room for two
//   results; an item can give two results and the output port sends one
//   result per cycle unless out_stall is high, so it sets the sustained rate
//   in_stall comes straight from the registered queue count, raised when
//   the four-entry result queue holds more than two items
//   reset clears all comment and string flags and empties the queue
//   while out_stall is high the head result holds steady on the output
// ----------------------------------------------------------------------------
module c_comment_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last_of_run
);

  ccs_pkg::push_t   push;
  ccs_pkg::result_t head_item;
  logic             accept;
  logic             almost_full;

  // an item is taken whenever the queue can absorb two results
  assign accept   = in_valid && !in_stall;
  assign in_stall = almost_full;

  // flags and decode of one byte into its results
  ccs_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_char (in_char),
    .push    (push)
  );

  // results wait here until the receiver takes them
  ccs_out_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pop         (!out_stall),
    .almost_full (almost_full),
    .not_empty   (out_valid),
    .head_item   (head_item)
  );

  assign out_char    = head_item.ch;
  assign last_of_run = head_item.last;

endmodule
